// File: rtl/core/sdrc_pkg.sv
// ----------------------------------------------------------------------------
// sdrc_pkg
// Types, constants and lookup tables shared by the stereo compressor.
// ----------------------------------------------------------------------------
package sdrc_pkg;

  localparam int SAMPLE_BITS       = 24;
  localparam int LOG_TABLE_ENTRIES = 256;
  localparam int LOG_BITS          = $clog2(LOG_TABLE_ENTRIES);
  localparam int LOG_E_W           = $clog2(SAMPLE_BITS);
  localparam int LOG_W             = LOG_E_W + 16;
  localparam int EXPO_W            = LOG_W + 1;
  localparam int Q_W               = EXPO_W - 16;
  localparam int RES_W             = SAMPLE_BITS + 5;
  localparam int THR_W             = 23;
  localparam int CFG_W             = 23;
  localparam int NUM_LANES         = 2;

  localparam logic [16:0] UNITY     = 17'd65536;
  localparam logic [Q_W-1:0] EXP_LIMIT = Q_W'(40);

  typedef enum logic [2:0] {
    REG_ENV_ATT  = 3'd0,
    REG_ENV_REL  = 3'd1,
    REG_THR      = 3'd2,
    REG_INV_RAT  = 3'd3,
    REG_GAIN_ATT = 3'd4,
    REG_GAIN_REL = 3'd5,
    REG_MAKEUP   = 3'd6,
    REG_BYPASS   = 3'd7
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAG, ST_ENV_MUL, ST_ENV_SUM, ST_LOG, ST_EXPO,
    ST_GC, ST_G_MUL, ST_G_SUM, ST_MK, ST_OUT, ST_DONE
  } step_e;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          clipped;
  } out_t;

  typedef struct packed {
    logic [15:0]      env_att;
    logic [15:0]      env_rel;
    logic [THR_W-1:0] thr;
    logic [16:0]      inv_ratio;
    logic [15:0]      gain_att;
    logic [15:0]      gain_rel;
    logic [15:0]      makeup;
    logic             bypass;
  } cfg_t;

  typedef struct packed {
    step_e step;
    logic  load;
  } lane_ctl_t;

  typedef struct packed {
    logic [RES_W-1:0]       r;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] samp;
  } lane_res_t;

  typedef logic [15:0] ltab_t [LOG_TABLE_ENTRIES];
  typedef logic [16:0] etab_t [LOG_TABLE_ENTRIES];

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bw;
    rem = v;
    res = '0;
    bw  = 64'd1 << 62;
    for (int i = 0; i < 32; i++) if (bw > rem) bw = bw >> 2;
    for (int i = 0; i < 32; i++) begin
      if (bw != 0) begin
        if (rem >= res + bw) begin
          rem = rem - (res + bw);
          res = (res >> 1) + bw;
        end else begin
          res = res >> 1;
        end
        bw = bw >> 2;
      end
    end
    return res;
  endfunction

  function automatic ltab_t gen_log_tab();
    ltab_t       t;
    logic [63:0] m;
    logic [15:0] res;
    for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
      m   = (64'd1 << 30) + (64'(i) << (30 - LOG_BITS));
      res = '0;
      for (int k = 1; k <= 16; k++) begin
        m = (m * m) >> 30;
        if (m >= (64'd1 << 31)) begin
          m = m >> 1;
          res[16-k] = 1'b1;
        end
      end
      t[i] = res;
    end
    return t;
  endfunction

  function automatic etab_t gen_exp_tab();
    etab_t       t;
    logic [63:0] ck [17];
    logic [63:0] c;
    logic [63:0] r;
    logic [15:0] t16;
    c = 64'd1 << 29;
    ck[0] = '0;
    for (int k = 1; k <= 16; k++) begin
      c = isqrt64(c << 30);
      ck[k] = c;
    end
    for (int j = 0; j < LOG_TABLE_ENTRIES; j++) begin
      t16 = 16'(j << (16 - LOG_BITS));
      r   = 64'd1 << 30;
      for (int k = 1; k <= 16; k++) begin
        if (t16[16-k]) r = (r * ck[k]) >> 30;
      end
      t[j] = 17'(r >> 14);
    end
    return t;
  endfunction

  localparam ltab_t LOG_TAB = gen_log_tab();
  localparam etab_t EXP_TAB = gen_exp_tab();

  // Q16 log2: leading-one position plus table of the top fraction bits
  function automatic logic [LOG_W-1:0] log2_q16(input logic [SAMPLE_BITS-1:0] v);
    logic [LOG_E_W-1:0]     e;
    logic [SAMPLE_BITS-1:0] norm;
    e = '0;
    for (int i = 0; i < SAMPLE_BITS; i++) if (v[i]) e = LOG_E_W'(i);
    norm = v << (LOG_E_W'(SAMPLE_BITS - 1) - e);
    return {e, LOG_TAB[norm[SAMPLE_BITS-2 -: LOG_BITS]]};
  endfunction

endpackage

// File: rtl/core/sdrc_lane.sv
// ----------------------------------------------------------------------------
// sdrc_lane
// One channel of the compressor: envelope, static curve, gain smoothing and
// gain application, sequenced one step per cycle.
// ----------------------------------------------------------------------------
module sdrc_lane import sdrc_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  lane_ctl_t              ctl_i,
  input  cfg_t                   cfg_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output lane_res_t              res_o
);

  logic [SAMPLE_BITS-1:0]    samp_q, mag_q, env_q;
  logic                      neg_q, under_q;
  logic [SAMPLE_BITS+15:0]   pa_q;
  logic [SAMPLE_BITS+16:0]   pb_q;
  logic [LOG_W-1:0]          diff_q;
  logic [EXPO_W-1:0]         expo_q;
  logic [16:0]               gc_q, g_q;
  logic [32:0]               ga_q;
  logic [33:0]               gb_q;
  logic [32:0]               pm_q;
  logic [RES_W-1:0]          r_q;

  logic [15:0]               env_c, gain_c;
  logic [16:0]               env_ci, gain_ci, ir_eff, one_ir;
  logic [THR_W-1:0]          thr_eff;
  logic [SAMPLE_BITS+17:0]   env_sum;
  logic [34:0]               g_sum;
  logic [LOG_W+16:0]         expo_prod;
  logic [Q_W-1:0]            q;
  logic [16:0]               gc_d;
  logic [SAMPLE_BITS+32:0]   out_prod;

  always_comb begin
    env_c    = (mag_q > env_q) ? cfg_i.env_att : cfg_i.env_rel;
    env_ci   = UNITY - {1'b0, env_c};
    gain_c   = (gc_q <= g_q) ? cfg_i.gain_att : cfg_i.gain_rel;
    gain_ci  = UNITY - {1'b0, gain_c};
    thr_eff  = (cfg_i.thr == '0) ? THR_W'(1) : cfg_i.thr;
    ir_eff   = (cfg_i.inv_ratio > UNITY) ? UNITY : cfg_i.inv_ratio;
    one_ir   = UNITY - ir_eff;
    env_sum  = {2'b0, pa_q} + {1'b0, pb_q} + (SAMPLE_BITS+18)'(32768);
    g_sum    = {2'b0, ga_q} + {1'b0, gb_q} + 35'd32768;
    expo_prod = diff_q * one_ir + (LOG_W+17)'(32768);
    q        = expo_q[EXPO_W-1:16];
    // two to the minus exponent: table for the fraction, shift for octaves
    if (under_q)             gc_d = UNITY;
    else if (q >= EXP_LIMIT) gc_d = '0;
    else                     gc_d = EXP_TAB[expo_q[15 -: LOG_BITS]] >> q;
    out_prod = mag_q * pm_q + (SAMPLE_BITS+33)'(1 << 27);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      env_q <= '0;
      g_q   <= UNITY;
    end else begin
      if (ctl_i.step == ST_ENV_SUM && !cfg_i.bypass)
        env_q <= env_sum[SAMPLE_BITS+15:16];
      if (ctl_i.step == ST_G_SUM && !cfg_i.bypass)
        g_q <= g_sum[32:16];
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (ctl_i.step)
      ST_IDLE:    if (ctl_i.load) samp_q <= sample_i;
      ST_MAG: begin
        neg_q <= samp_q[SAMPLE_BITS-1];
        mag_q <= samp_q[SAMPLE_BITS-1] ? (~samp_q + 1'b1) : samp_q;
      end
      ST_ENV_MUL: begin
        pa_q <= env_c * env_q;
        pb_q <= env_ci * mag_q;
      end
      ST_LOG: begin
        under_q <= (env_q < thr_eff);
        diff_q  <= log2_q16(env_q) - log2_q16(SAMPLE_BITS'(thr_eff));
      end
      ST_EXPO:    expo_q <= expo_prod[LOG_W+16:16];
      ST_GC:      gc_q <= gc_d;
      ST_G_MUL: begin
        ga_q <= gain_c * g_q;
        gb_q <= gain_ci * gc_q;
      end
      ST_MK:      pm_q <= g_q * cfg_i.makeup;
      ST_OUT:     r_q <= out_prod[SAMPLE_BITS+32:28];
      default: ;
    endcase
  end

  assign res_o = '{r: r_q, neg: neg_q, samp: samp_q};

endmodule

// File: rtl/core/sdrc_merge.sv
// ----------------------------------------------------------------------------
// sdrc_merge
// Saturates both lane results (or passes the raw samples in bypass), merges the
// clip flags and holds the output request until it is taken.
// ----------------------------------------------------------------------------
module sdrc_merge import sdrc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_res_t res_i [NUM_LANES],
  input  logic      load_i,
  input  logic      bypass_i,
  input  logic      out_stall_i,
  output logic      free_o,
  output logic      out_valid_o,
  output out_t      out_o
);

  localparam logic [RES_W-1:0] POS_MAX = RES_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RES_W-1:0] NEG_MAX = RES_W'(1 << (SAMPLE_BITS - 1));

  logic                   out_valid_q;
  out_t                   out_q, out_d;
  logic [SAMPLE_BITS-1:0] val [NUM_LANES];
  logic [NUM_LANES-1:0]   clip;

  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      clip[i] = 1'b0;
      if (!res_i[i].neg) begin
        if (res_i[i].r > POS_MAX) begin
          val[i]  = POS_MAX[SAMPLE_BITS-1:0];
          clip[i] = 1'b1;
        end else begin
          val[i] = res_i[i].r[SAMPLE_BITS-1:0];
        end
      end else begin
        if (res_i[i].r > NEG_MAX) begin
          val[i]  = ~NEG_MAX[SAMPLE_BITS-1:0] + 1'b1;
          clip[i] = 1'b1;
        end else begin
          val[i] = ~res_i[i].r[SAMPLE_BITS-1:0] + 1'b1;
        end
      end
    end
    if (bypass_i) begin
      out_d = '{left_out: res_i[0].samp, right_out: res_i[1].samp, clipped: 1'b0};
    end else begin
      out_d = '{left_out: val[0], right_out: val[1], clipped: |clip};
    end
  end

  assign free_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_i) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

// File: rtl/core/stereo_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// stereo_dynamic_range_compressor
// Feed-forward peak-envelope compressor, one stereo pair per request.
// ----------------------------------------------------------------------------
// A request is accepted in the idle step; the pair then runs through ten
// arithmetic steps and one hand-over step, which loads the output register,
// and the block returns to idle before it can take the next pair. A stalled
// output holds the hand-over step for the length of the stall. Both channels
// run in two identical lanes side by side, each stepping through magnitude,
// envelope multiply and sum, log lookup, exponent multiply, gain lookup, gain
// smoothing, makeup and output multiply. A finished result waits in the output
// register while the next pair is already being worked on.
module stereo_dynamic_range_compressor import sdrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i
);

  step_e     step_q, step_d;
  cfg_t      cfg_q;
  lane_ctl_t ctl;
  lane_res_t res [NUM_LANES];
  logic      accept, free, load_out;

  assign accept = in_valid_i && (step_q == ST_IDLE);
  assign in_stall_o = (step_q != ST_IDLE);

  always_comb begin
    step_d   = step_q;
    load_out = 1'b0;
    unique case (step_q)
      ST_IDLE:    if (accept) step_d = ST_MAG;
      ST_MAG:     step_d = ST_ENV_MUL;
      ST_ENV_MUL: step_d = ST_ENV_SUM;
      ST_ENV_SUM: step_d = ST_LOG;
      ST_LOG:     step_d = ST_EXPO;
      ST_EXPO:    step_d = ST_GC;
      ST_GC:      step_d = ST_G_MUL;
      ST_G_MUL:   step_d = ST_G_SUM;
      ST_G_SUM:   step_d = ST_MK;
      ST_MK:      step_d = ST_OUT;
      ST_OUT:     step_d = ST_DONE;
      ST_DONE: begin
        if (free) begin
          load_out = 1'b1;
          step_d   = ST_IDLE;
        end
      end
      default:    step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) step_q <= ST_IDLE;
    else         step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{env_att: 16'd0, env_rel: 16'd0, thr: THR_W'(8388607),
                 inv_ratio: UNITY, gain_att: 16'd0, gain_rel: 16'd0,
                 makeup: 16'd4096, bypass: 1'b0};
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ENV_ATT:  cfg_q.env_att   <= cfg_wdata_i[15:0];
        REG_ENV_REL:  cfg_q.env_rel   <= cfg_wdata_i[15:0];
        REG_THR:      cfg_q.thr       <= cfg_wdata_i[THR_W-1:0];
        REG_INV_RAT:  cfg_q.inv_ratio <= cfg_wdata_i[16:0];
        REG_GAIN_ATT: cfg_q.gain_att  <= cfg_wdata_i[15:0];
        REG_GAIN_REL: cfg_q.gain_rel  <= cfg_wdata_i[15:0];
        REG_MAKEUP:   cfg_q.makeup    <= cfg_wdata_i[15:0];
        REG_BYPASS:   cfg_q.bypass    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  assign ctl = '{step: step_q, load: accept};

  sdrc_lane u_lane_l (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .sample_i (in_i.left_sample),
    .res_o    (res[0])
  );

  sdrc_lane u_lane_r (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .cfg_i    (cfg_q),
    .sample_i (in_i.right_sample),
    .res_o    (res[1])
  );

  sdrc_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .load_i      (load_out),
    .bypass_i    (cfg_q.bypass),
    .out_stall_i (out_stall_i),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_o       (out_o)
  );

endmodule

// File: rtl/core/sdrc_checker.sv
// ----------------------------------------------------------------------------
// sdrc_checker
// Port-level checks on the compressor, bound to the top level.
// ----------------------------------------------------------------------------
module sdrc_checker import sdrc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_t             out_o
);

  localparam logic signed [SAMPLE_BITS-1:0] SMAX = SAMPLE_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = ~SMAX;

  // a held request stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))
    else $error("output request dropped or changed under stall");

  // one pair in flight: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a pair is in flight");

  // no new result appears in the cycle after an acceptance made while no output was valid
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

  // clip flag only with a saturated channel
  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.clipped |->
      (out_o.left_out == SMAX) || (out_o.left_out == SMIN) ||
      (out_o.right_out == SMAX) || (out_o.right_out == SMIN))
    else $error("clip flag without saturated output");

endmodule

bind stereo_dynamic_range_compressor sdrc_checker u_sdrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_o       (out_o)
);

// File: dv/compressor_scoreboard.sv
// ----------------------------------------------------------------------------
// compressor_scoreboard
// Watches the request, result and register ports of the stereo compressor,
// keeps its own copy of the envelope and gain state, predicts each result
// and compares it field by field with what the block delivers.
// ----------------------------------------------------------------------------
module compressor_scoreboard import sdrc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  in_t              in_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  out_t             out_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o,
  output int               clips_o
);

  logic [15:0] env_att_q, env_rel_q, gain_att_q, gain_rel_q, makeup_q;
  logic [22:0] thr_q;
  logic [16:0] inv_ratio_q;
  logic        bypass_q;
  logic [23:0] env_l, env_r;
  logic [16:0] gain_l, gain_r;
  logic [63:0] half_root [1:16];
  out_t        awaited [$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] acc, trial;
    acc = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  // successive square roots of one half, Q30
  initial begin
    logic [63:0] c;
    c = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      c = floor_sqrt(c << 30);
      half_root[k] = c;
    end
  end

  function automatic logic [63:0] log_q16(input logic [63:0] v);
    logic [63:0] msb, frac, idx, m, acc;
    msb = 0;
    for (int i = 0; i < 63; i++) if ((v >> (i + 1)) != 0) msb = i + 1;
    frac = ((v << 16) >> msb) - 64'd65536;
    idx  = (frac * LOG_TABLE_ENTRIES) >> 16;
    m    = (64'd1 << 30) + ((idx << 30) / LOG_TABLE_ENTRIES);
    acc  = 0;
    for (int k = 1; k <= 16; k++) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        acc[16-k] = 1'b1;
      end
    end
    return (msb << 16) + acc;
  endfunction

  function automatic logic [63:0] pow2_neg(input logic [63:0] e16);
    logic [63:0] oct, step, t16, r;
    oct = e16 >> 16;
    if (oct >= 40) return 0;
    step = ((e16 & 64'hFFFF) * LOG_TABLE_ENTRIES) >> 16;
    t16  = (step << 16) / LOG_TABLE_ENTRIES;
    r    = 64'd1 << 30;
    for (int k = 1; k <= 16; k++) if (t16[16-k]) r = (r * half_root[k]) >> 30;
    return (r >> 14) >> oct;
  endfunction

  function automatic logic [63:0] blend(input logic [63:0] c, prev, nxt);
    return (c * prev + (64'd65536 - c) * nxt + 64'd32768) >> 16;
  endfunction

  function automatic logic [23:0] compress_lane(input logic [23:0] x,
                                                inout logic [23:0] env,
                                                inout logic [16:0] g,
                                                inout logic clip);
    logic [63:0] mag, thr, ir, e, gc, gs, r;
    logic        neg;
    neg = x[23];
    mag = neg ? 64'(24'(-x)) : 64'(x);
    thr = (thr_q == 0) ? 64'd1 : 64'(thr_q);
    ir  = (inv_ratio_q > 17'd65536) ? 64'd65536 : 64'(inv_ratio_q);
    e   = blend(mag > env ? 64'(env_att_q) : 64'(env_rel_q), 64'(env), mag);
    env = e[23:0];
    if (e < thr) gc = 64'd65536;
    else gc = pow2_neg(((log_q16(e) - log_q16(thr)) * (64'd65536 - ir) + 64'd32768) >> 16);
    gs = blend(gc <= g ? 64'(gain_att_q) : 64'(gain_rel_q), 64'(g), gc);
    g  = gs[16:0];
    r  = (mag * (gs * 64'(makeup_q)) + (64'd1 << 27)) >> 28;
    if (!neg) begin
      if (r > 64'h7FFFFF) begin
        r = 64'h7FFFFF;
        clip = 1'b1;
      end
      return r[23:0];
    end
    if (r > 64'h800000) begin
      r = 64'h800000;
      clip = 1'b1;
    end
    return 24'(-r);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t exp_res, got;
    logic clip;
    if (!rst_ni) begin
      env_att_q <= 0; env_rel_q <= 0; thr_q <= 23'd8388607; inv_ratio_q <= 17'd65536;
      gain_att_q <= 0; gain_rel_q <= 0; makeup_q <= 16'd4096; bypass_q <= 0;
      env_l <= 0; env_r <= 0; gain_l <= 17'd65536; gain_r <= 17'd65536;
      errors_o <= 0; results_o <= 0; clips_o <= 0;
      awaited.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_ENV_ATT:  env_att_q   <= cfg_wdata_i[15:0];
          REG_ENV_REL:  env_rel_q   <= cfg_wdata_i[15:0];
          REG_THR:      thr_q       <= cfg_wdata_i[22:0];
          REG_INV_RAT:  inv_ratio_q <= cfg_wdata_i[16:0];
          REG_GAIN_ATT: gain_att_q  <= cfg_wdata_i[15:0];
          REG_GAIN_REL: gain_rel_q  <= cfg_wdata_i[15:0];
          REG_MAKEUP:   makeup_q    <= cfg_wdata_i[15:0];
          REG_BYPASS:   bypass_q    <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        if (bypass_q) begin
          exp_res = '{left_out: in_i.left_sample, right_out: in_i.right_sample, clipped: 1'b0};
        end else begin
          logic [23:0] el, er;
          logic [16:0] gl, gr;
          el = env_l; er = env_r; gl = gain_l; gr = gain_r;
          clip = 1'b0;
          exp_res.left_out  = compress_lane(in_i.left_sample, el, gl, clip);
          exp_res.right_out = compress_lane(in_i.right_sample, er, gr, clip);
          exp_res.clipped   = clip;
          env_l <= el; env_r <= er; gain_l <= gl; gain_r <= gr;
        end
        awaited.push_back(exp_res);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_i;
        results_o <= results_o + 1;
        if (got.clipped) clips_o <= clips_o + 1;
        if (awaited.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors_o <= errors_o + 1;
        end else begin
          exp_res = awaited.pop_front();
          if (got.left_out !== exp_res.left_out || got.right_out !== exp_res.right_out ||
              got.clipped !== exp_res.clipped) begin
            $display("%0t: mismatch expected L=%h R=%h clip=%b, actual L=%h R=%h clip=%b",
                     $time, exp_res.left_out, exp_res.right_out, exp_res.clipped,
                     got.left_out, got.right_out, got.clipped);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  always_comb pending_o = awaited.size();

endmodule

// File: dv/tb_stereo_dynamic_range_compressor.sv
// ----------------------------------------------------------------------------
// tb_stereo_dynamic_range_compressor
// Drives stereo sample requests through the compressor over a series of
// register settings (defaults, hard compression with clipping, bypass, edge
// values and random ones) with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_stereo_dynamic_range_compressor;
  import sdrc_pkg::*;

  logic             clk_i = 0;
  logic             rst_ni = 0;
  logic             in_valid_i = 0;
  logic             in_stall_o;
  in_t              in_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 0;
  out_t             out_o;
  logic             cfg_we_i = 0;
  logic [2:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int               errors, pending, results, clips;
  int               sent = 0;
  int               idle_run = 0;
  bit               quiet = 0;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  stereo_dynamic_range_compressor dut (.*);

  compressor_scoreboard scoreboard (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_i(out_o),
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending), .results_o(results), .clips_o(clips)
  );

  always @(negedge clk_i) out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 10);

  // watchdog on cycles with no request or result moving
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_run <= 0;
    else idle_run <= idle_run + 1;
    if (idle_run > 5000) begin
      $display("tb_stereo_dynamic_range_compressor NOT OK");
      $finish;
    end
  end

  task automatic drain();
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= CFG_W'(val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_all(input int unsigned ea, er, thr, ir, ga, gr, mk, byp);
    drain();
    write_reg(REG_ENV_ATT, ea);
    write_reg(REG_ENV_REL, er);
    write_reg(REG_THR, thr);
    write_reg(REG_INV_RAT, ir);
    write_reg(REG_GAIN_ATT, ga);
    write_reg(REG_GAIN_REL, gr);
    write_reg(REG_MAKEUP, mk);
    write_reg(REG_BYPASS, byp);
  endtask

  function automatic logic [23:0] pick_sample();
    case ($urandom_range(9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'(-$urandom_range(4000));
      3: return 24'($urandom_range(4000));
      default: return 24'($urandom);
    endcase
  endfunction

  // called at a falling edge; returns at a falling edge after acceptance
  task automatic send_pair(input logic [23:0] l, r);
    in_i       <= '{left_sample: l, right_sample: r};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    sent++;
    if (!quiet && $urandom_range(99) < 10) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
  endtask

  task automatic random_pairs(input int n);
    for (int i = 0; i < n; i++) send_pair(pick_sample(), pick_sample());
    in_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // defaults: unity gain
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h000000, 24'h000001);
    send_pair(24'hFFFFFF, 24'h555555);
    in_valid_i <= 1'b0;

    // hard compression, zero threshold, heavy makeup so outputs clip
    set_all(0, 0, 0, 1, 0, 0, 65535, 0);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h000001, 24'hFFFFFF);
    send_pair(24'h000000, 24'h000000);
    send_pair(24'h000100, 24'hFFFF00);
    send_pair(24'hAAAAAA, 24'h555555);
    in_valid_i <= 1'b0;

    // ratio word above unity and slowest smoothing
    set_all(65535, 65535, 1, 131071, 65535, 65535, 4096, 0);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h400000, 24'hC00000);
    in_valid_i <= 1'b0;

    // bypass with state left alone
    drain();
    write_reg(REG_BYPASS, 1);
    send_pair(24'h7FFFFF, 24'h800000);
    send_pair(24'h123456, 24'hEDCBA9);
    in_valid_i <= 1'b0;
    drain();
    write_reg(REG_BYPASS, 0);

    // moderate settings with no idling on either side
    set_all(8000, 60000, 1000000, 16384, 2000, 64000, 8192, 0);
    quiet = 1;
    random_pairs(120);
    quiet = 0;

    // random settings, one phase with the sender pausing until results drain
    for (int p = 0; p < 4; p++) begin
      set_all($urandom_range(65535), $urandom_range(65535), $urandom_range(1, 8388607),
              $urandom_range(1, 65536), $urandom_range(65535), $urandom_range(65535),
              $urandom_range(65535), 0);
      random_pairs(50);
      if (p == 1) drain();
      random_pairs(50);
    end

    set_all(0, 65535, 8388607, 65536, 65535, 0, 0, 0);
    random_pairs(40);
    set_all(30000, 30000, 100, 1, 0, 65535, 65535, 0);
    random_pairs(60);
    drain();
    write_reg(REG_BYPASS, 1);
    random_pairs(20);

    drain();
    $display("Sent %0d sample pairs, checked %0d results (%0d clipped),", sent, results, clips);
    $display("over default, bypass, extreme and random register settings.");
    if (errors == 0) $display("tb_stereo_dynamic_range_compressor OK");
    else $display("tb_stereo_dynamic_range_compressor NOT OK");
    $finish;
  end

endmodule
